// File: hw/rtl/fp12c_pkg.sv
// ============================================================================
// fp12c_pkg
// Shared codes and constants of the FP12 format converter.
// ============================================================================
package fp12c_pkg;

    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_INT_TO_FP12   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FP12_TO_INT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLOAT_TO_FP12 = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FP12_TO_FLOAT = 2'd3;

    localparam logic [15:0] FP12_NEG_SIGN     = 16'hf800;
    localparam logic [15:0] FP12_INT_MIN_CODE = 16'hffc0;
    localparam logic [31:0] F32_NAN_PAYLOAD   = 32'h0001ffff;
    localparam logic [31:0] INT_MIN_BITS      = 32'h80000000;

    // in: req 2, int 32, float 32, fp12 16 = 82 bits -> 88
    localparam int IN_DATA_W  = 88;
    // out: fp12 16, int 32, float 32 = 80 bits
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [31:0]      int_in;
        logic [31:0]      float_in;
        logic [15:0]      fp12_in;
    } req_t;

    typedef struct packed {
        logic [15:0] fp12_out;
        logic [31:0] int_out;
        logic [31:0] float_out;
    } res_t;

endpackage

// File: hw/rtl/fp12_format_converter_top.sv
// ============================================================================
// fp12_format_converter_top
// Stream wrapper around the FP12 conversion logic.
// ============================================================================
// Takes one request per cycle while the output is not stalled: a transfer is
// registered, converted by one stage of combinational logic and held in an
// output register. The input register refills whenever the output register
// is free or being drained.
module fp12_format_converter_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // req_type[1:0], int_in[33:2], float_in[65:34], fp12_in[81:66], zero pad
    input  logic [fp12c_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fp12_out[15:0], int_out[47:16], float_out[79:48]
    output logic [fp12c_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import fp12c_pkg::*;

    logic  in_vld_reg, in_vld_next;
    req_t  in_reg;
    logic  out_vld_reg, out_vld_next;
    res_t  out_reg;
    res_t  conv;
    logic  adv;

    fp12c_core u_core (.req(in_reg), .res(conv));

    // advance when output slot is empty or drained
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || adv;

    always_comb
    begin
        in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
        out_vld_next = adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // hold payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.req_type <= s_tdata[1:0];
            in_reg.int_in   <= s_tdata[33:2];
            in_reg.float_in <= s_tdata[65:34];
            in_reg.fp12_in  <= s_tdata[81:66];
        end
        if (adv && in_vld_reg) out_reg <= conv;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.float_out, out_reg.int_out, out_reg.fp12_out};

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    // at most one result field is nonzero
    a_onefield: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones({|out_reg.fp12_out, |out_reg.int_out,
                                 |out_reg.float_out}) <= 1)
        else $error("more than one result field set");
    // a full pipe with a stalled output refuses input
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !m_tready |-> !s_tready)
        else $error("accepted into full pipe");

endmodule

// File: hw/rtl/fp12c_core.sv
// ============================================================================
// fp12c_core
// Combinational conversion of one request into its result fields.
// ============================================================================
module fp12c_core
(
    input  fp12c_pkg::req_t req,
    output fp12c_pkg::res_t res
);
    import fp12c_pkg::*;

    // ---------------- integer to FP12 ----------------
    logic [31:0] i_mag;
    logic [4:0]  i_top;
    logic [31:0] i_norm;
    logic [6:0]  i_frac;
    logic        i_rb, i_sticky;
    logic [5:0]  i_exp;
    logic [15:0] i_res;

    always_comb
    begin
        i_mag = req.int_in[31] ? (~req.int_in + 32'd1) : req.int_in;
        i_top = 5'd0;
        for (int k = 1; k < 31; k++)
        begin
            if (i_mag[k]) i_top = 5'(k);
        end
        // left-justify so the leading one lands at bit 31
        i_norm   = i_mag << (5'd31 - i_top);
        i_frac   = {1'b0, i_norm[31:26]};
        i_rb     = i_norm[25];
        i_sticky = |i_norm[24:0];
        if (i_rb && (i_sticky || i_frac[0])) i_frac = i_frac + 7'd1;
        i_exp = 6'(i_top) + 6'd31;
        if (i_frac[6])
        begin
            i_exp  = i_exp + 6'd1;
            i_frac = i_frac >> 1;
        end
        i_res = (req.int_in[31] ? FP12_NEG_SIGN : 16'h0) | {5'd0, i_exp, i_frac[4:0]};
        if (req.int_in == 32'd0) i_res = 16'h0;
        else if (req.int_in == INT_MIN_BITS) i_res = FP12_INT_MIN_CODE;
    end

    // ---------------- FP12 to integer ----------------
    logic [5:0]  h_e;
    logic [4:0]  h_f;
    logic        h_neg;
    logic [31:0] h_n;
    logic [36:0] h_sig;

    always_comb
    begin
        h_e   = req.fp12_in[10:5];
        h_f   = req.fp12_in[4:0];
        h_neg = |req.fp12_in[15:11];
        // value = 1.f * 2^(e-31), p = e-31 in 0..30
        h_sig = '0;
        h_n   = 32'd0;
        if (h_e >= 6'd31)
        begin
            h_sig = {31'd0, 1'b1, h_f} << (h_e - 6'd31);
            h_n   = h_sig[36:5];
        end
        if (h_neg) h_n = ~h_n + 32'd1;
        if (h_e >= 6'd62) h_n = INT_MIN_BITS;
    end

    // ---------------- float to FP12 ----------------
    logic [7:0]  f_be;
    logic [23:0] f_full;
    logic [15:0] f_sign;
    logic [6:0]  f_frac;
    logic        f_rb, f_sticky;
    logic [4:0]  f_sh;
    logic [23:0] f_shd;
    logic [15:0] f_res;
    logic [5:0]  f_exp;

    always_comb
    begin
        f_be   = req.float_in[30:23];
        f_full = {1'b1, req.float_in[22:0]};
        f_sign = req.float_in[31] ? FP12_NEG_SIGN : 16'h0;
        f_sh = 5'd0; f_shd = '0; f_frac = '0; f_rb = 1'b0; f_sticky = 1'b0;
        f_exp = 6'(f_be - 8'd96);
        if (f_be > 8'd158)
            f_res = f_sign | {5'd0, 6'd63, 4'd0,
                              (f_be == 8'd255) && (|req.float_in[22:0])};
        else if (f_be < 8'd91)
            f_res = f_sign;
        else if (f_be > 8'd96)
        begin
            f_frac   = {1'b0, f_full[23:18]};
            f_sticky = |f_full[16:0];
            f_rb     = f_full[17];
            if (f_rb && (f_sticky || f_frac[0])) f_frac = f_frac + 7'd1;
            if (f_frac[6]) f_res = f_sign | {5'd0, f_exp + 6'd1, 5'd0};
            else           f_res = f_sign | {5'd0, f_exp, f_frac[4:0]};
        end
        else
        begin
            // s = 115 - be in 19..24
            f_sh     = 5'(8'd115 - f_be);
            f_shd    = f_full >> f_sh;
            f_rb     = f_full[f_sh - 5'd1];
            f_sticky = |(f_full & ((24'd1 << (f_sh - 5'd1)) - 24'd1));
            f_frac   = {1'b0, f_shd[5:0]};
            if (f_rb && (f_sticky || f_frac[0])) f_frac = f_frac + 7'd1;
            if (f_frac[5]) f_res = f_sign | 16'h0020;
            else           f_res = f_sign | {11'd0, f_frac[4:0]};
        end
    end

    // ---------------- FP12 to float ----------------
    logic [31:0] g_res;
    logic [31:0] g_sign;
    logic [2:0]  g_pos;
    logic [4:0]  g_rest;

    always_comb
    begin
        g_sign = h_neg ? INT_MIN_BITS : 32'd0;
        g_pos  = 3'd0;
        for (int k = 0; k < 5; k++)
        begin
            if (h_f[k]) g_pos = 3'(k);
        end
        g_rest = h_f & ((5'd1 << g_pos) - 5'd1);
        if (h_e == 6'd63)
            g_res = g_sign | {1'b0, 8'hff, 23'd0} | (|h_f ? F32_NAN_PAYLOAD : 32'd0);
        else if (h_e != 6'd0)
            g_res = g_sign | {1'b0, 8'(h_e) + 8'd96, h_f, 18'd0};
        else if (h_f == 5'd0)
            g_res = g_sign;
        else
            g_res = g_sign | {1'b0, 8'd92 + 8'(g_pos), 23'({g_rest, 18'd0}) << (3'd5 - g_pos)};
    end

    // ---------------- select ----------------
    always_comb
    begin
        res = '0;
        unique case (req.req_type)
            REQ_INT_TO_FP12:   res.fp12_out  = i_res;
            REQ_FP12_TO_INT:   res.int_out   = h_n;
            REQ_FLOAT_TO_FP12: res.fp12_out  = f_res;
            REQ_FP12_TO_FLOAT: res.float_out = g_res;
            default:           res = '0;
        endcase
    end

endmodule

// File: bench/tb_fp12_format_converter_top.sv
// ============================================================================
// tb_fp12_format_converter_top
// Stream-level test of the FP12 format converter: every transfer is predicted
// by an independent conversion model and each output transfer is compared
// field by field in order, under random and held-off handshakes.
// ============================================================================
`timescale 1ns / 100ps

module tb_fp12_format_converter_top;
    import fp12c_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    typedef struct packed {
        logic [15:0] fp12;
        logic [31:0] ival;
        logic [31:0] fval;
    } conv_res_t;

    conv_res_t   expected_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          hold_cycles;

    fp12_format_converter_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Integer to FP12, round to nearest even
    function automatic logic [15:0] int_to_fp12(logic [31:0] bits);
        logic [15:0] sgn;
        logic [31:0] mag;
        logic [31:0] frac;
        int          msb;
        bit          lsb, rnd, stk;
        sgn = 16'h0;
        msb = 0;
        if (bits == 32'h0) return 16'h0;
        if (bits == INT_MIN_BITS) return FP12_INT_MIN_CODE;
        if (bits[31])
        begin
            sgn = FP12_NEG_SIGN;
            mag = (~bits + 32'd1) & 32'h7fffffff;
        end
        else
            mag = bits;
        for (int i = 1; i <= 30; i++)
            if (mag >> i != 0) msb = i;
        if (msb >= 5)
        begin
            frac = mag >> (msb - 5);
            lsb = frac[0];
            rnd = (msb > 5) && mag[msb-6];
            stk = (msb > 6) && ((mag & ((32'd1 << (msb - 6)) - 1)) != 0);
            if (rnd && (stk || lsb)) frac++;
        end
        else
            frac = mag << (5 - msb);
        if (frac[6])
        begin
            msb++;
            frac = frac >> 1;
        end
        return sgn | 16'((msb + 31) << 5) | 16'(frac & 31);
    endfunction

    // FP12 to integer, truncate toward zero
    function automatic logic [31:0] fp12_to_int(logic [15:0] w);
        int unsigned e;
        logic [31:0] frac;
        logic [31:0] n;
        int          p;
        e = w[10:5];
        frac = {27'd0, w[4:0]};
        n = 0;
        if (e >= 62) return INT_MIN_BITS;
        p = int'(e) + ((e != 0) ? 0 : 1) - 31;
        if (p >= 0)
        begin
            if (p >= 5) frac = frac << (p - 5);
            else frac = frac >> (5 - p);
            n = (32'd1 << p) + frac;
        end
        if (w[15:11] != 0) n = ~n + 32'd1;
        return n;
    endfunction

    // IEEE single to FP12
    function automatic logic [15:0] float_to_fp12(logic [31:0] b);
        logic [15:0] sgn;
        logic [31:0] full;
        logic [31:0] frac;
        int          p, s;
        bit          lsb, rnd, stk;
        sgn = b[31] ? FP12_NEG_SIGN : 16'h0;
        p = int'(b[30:23]) - 127;
        full = {8'd0, 1'b1, b[22:0]};
        if (p > 31)
            return sgn | 16'(63 << 5) | ((b[30:23] == 8'hff && b[22:0] != 0) ? 16'd1 : 16'd0);
        if (p < -36) return sgn;
        if (p > -31)
        begin
            frac = full >> 18;
            stk = (full & 32'h1ffff) != 0;
            rnd = full[17];
            lsb = full[18];
            if (rnd && (stk || lsb))
            begin
                frac++;
                if (frac > 63) return sgn | 16'((p + 32) << 5);
            end
            return sgn | 16'((p + 31) << 5) | 16'(frac & 31);
        end
        s = -p - 12;
        stk = (full & ((32'd1 << (s - 1)) - 1)) != 0;
        rnd = full[s-1];
        lsb = full[s];
        frac = full >> s;
        if (rnd && (stk || lsb))
        begin
            frac++;
            if (frac > 31) return sgn | 16'h0020;
        end
        return sgn | 16'(frac & 31);
    endfunction

    // FP12 to IEEE single, exact
    function automatic logic [31:0] fp12_to_float(logic [15:0] w);
        logic [31:0] sgn;
        logic [31:0] e;
        logic [31:0] frac;
        sgn = (w[15:11] != 0) ? 32'h80000000 : 32'h0;
        e = {26'd0, w[10:5]};
        frac = {27'd0, w[4:0]};
        if (e == 63) return sgn | (32'd255 << 23) | ((frac != 0) ? F32_NAN_PAYLOAD : 32'd0);
        if (e != 0) return sgn | ((e + 32'd96) << 23) | (frac << 18);
        for (int pos = 4; pos >= 0; pos--)
            if (frac[pos])
                return sgn | (32'(92 + pos) << 23)
                       | ((frac & ((32'd1 << pos) - 1)) << (23 - pos));
        return sgn;
    endfunction

    function automatic conv_res_t predict_conversion(req_t r);
        conv_res_t res;
        res = '0;
        case (r.req_type)
            REQ_INT_TO_FP12:   res.fp12 = int_to_fp12(r.int_in);
            REQ_FP12_TO_INT:   res.ival = fp12_to_int(r.fp12_in);
            REQ_FLOAT_TO_FP12: res.fp12 = float_to_fp12(r.float_in);
            default:           res.fval = fp12_to_float(r.fp12_in);
        endcase
        return res;
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(logic [1:0] op, logic [31:0] iv, logic [31:0] fv,
                                logic [15:0] hv);
        req_t r;
        r.req_type = op;
        r.int_in   = iv;
        r.float_in = fv;
        r.fp12_in  = hv;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, hv, fv, iv, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_conversion(r));
    endtask

    // Receiver: random backpressure plus optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off && hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        conv_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (m_tdata[15:0] !== exp_r.fp12)
                begin
                    $display("%0t: fp12_out expected %h actual %h", $time, exp_r.fp12,
                             m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[47:16] !== exp_r.ival)
                begin
                    $display("%0t: int_out expected %h actual %h", $time, exp_r.ival,
                             m_tdata[47:16]);
                    errors++;
                end
                if (m_tdata[79:48] !== exp_r.fval)
                begin
                    $display("%0t: float_out expected %h actual %h", $time, exp_r.fval,
                             m_tdata[79:48]);
                    errors++;
                end
            end
        end
    end

    // Drop the offer and wait for every pending result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(REQ_INT_TO_FP12, 32'd0, 0, 0);
        send_request(REQ_INT_TO_FP12, 32'h80000000, 0, 0);
        send_request(REQ_INT_TO_FP12, 32'h7fffffff, 0, 0);
        send_request(REQ_INT_TO_FP12, 32'hffffffff, 0, 0);
        send_request(REQ_INT_TO_FP12, 32'd13, 0, 0);
        send_request(REQ_INT_TO_FP12, 32'd100, 0, 0);   // exactly representable, no rounding
        send_request(REQ_INT_TO_FP12, 32'd127, 0, 0);   // carry raises exponent
        send_request(REQ_FP12_TO_INT, 0, 0, 16'h07c0);
        send_request(REQ_FP12_TO_INT, 0, 0, 16'h07e5);
        send_request(REQ_FP12_TO_INT, 0, 0, 16'h0800 | 16'h03e3);
        send_request(REQ_FP12_TO_INT, 0, 0, 16'h001f);
        send_request(REQ_FP12_TO_INT, 0, 0, 16'hffff);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h7f800000, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'hffc00001, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h80000001, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h2d800000, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h307fffff, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h4f7fffff, 0);
        send_request(REQ_FLOAT_TO_FP12, 0, 32'h3f860000, 0);
        send_request(REQ_FP12_TO_FLOAT, 0, 0, 16'h07e1);
        send_request(REQ_FP12_TO_FLOAT, 0, 0, 16'hffe0);
        send_request(REQ_FP12_TO_FLOAT, 0, 0, 16'h0013);
        send_request(REQ_FP12_TO_FLOAT, 0, 0, 16'h8000);
        send_request(REQ_FP12_TO_FLOAT, 0, 0, 16'h0000);
        wait_drained();
    endtask

    // Random requests; float exponents clustered around the FP12 range
    task automatic test_random(int count);
        logic [31:0] iv, fv;
        logic [15:0] hv;
        for (int i = 0; i < count; i++)
        begin
            iv = $urandom;
            if ($urandom_range(1)) iv = iv >> $urandom_range(31);
            fv = $urandom;
            if ($urandom_range(3) != 0) fv[30:23] = 8'($urandom_range(85, 162));
            hv = 16'($urandom);
            if ($urandom_range(1)) hv[15:11] = {5{hv[15]}};
            send_request(2'($urandom_range(3)), iv, fv, hv);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 60;
        hold_off = 1'b1;
        test_random(20);
        hold_off = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 16;
        recv_idle_pct = 69;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(230);
        wait_drained();
        send_idle_pct = 69;
        recv_idle_pct = 16;
        test_random(230);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        test_backpressure();
        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
